### src/tsmp_pkg.sv
`timescale 1ns / 1ps

package tsmp_pkg;

   // Field widths.
   localparam int PosW  = 16;
   localparam int SpdW  = 20;
   localparam int StepW = 16;
   localparam int RateW = 29;
   localparam int MaxW  = 19;
   localparam int TolW  = 15;

   // Shared multiplier: signed 30 x signed 17 gives a 47-bit product.
   localparam int MulAW = 30;
   localparam int MulBW = 17;
   localparam int ProdW = MulAW + MulBW;

   // Travel bound (1.0 in Q2.14) and the hard speed limit (16.0).
   localparam logic signed [PosW-1:0] POS_ONE   = 16'sd16384;
   localparam logic [MaxW-1:0]        SPEED_CAP = 19'd262144;

   // Register reset values.
   localparam logic [MaxW-1:0]  MAX_SPEED_RST = 19'd163840;
   localparam logic [RateW-1:0] ACCEL_RST     = 29'd16384000;
   localparam logic [RateW-1:0] DECEL_RST     = 29'd163840000;
   localparam logic [TolW-1:0]  TOL_RST       = 15'd164;

   typedef enum logic [1:0] {
      REG_MAX_SPEED,
      REG_ACCEL_RATE,
      REG_DECEL_RATE,
      REG_REACH_TOL
   } reg_index_type;

   typedef struct packed {
      logic [MaxW-1:0]  max_speed;
      logic [RateW-1:0] accel_rate;
      logic [RateW-1:0] decel_rate;
      logic [TolW-1:0]  reach_tolerance;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE,
      ST_SPEED,
      ST_MOVE,
      ST_COMMIT
   } seq_state_type;

endpackage

### src/tsmp_csr.sv
`timescale 1ns / 1ps

module tsmp_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output tsmp_pkg::cfg_type      cfg
);

   tsmp_pkg::cfg_type       cfg_ff;
   tsmp_pkg::cfg_type       cfg_in;
   tsmp_pkg::reg_index_type index;
   logic                    wr_en;

   assign index      = tsmp_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write decode: the access cycle of a write transfer updates one register.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            tsmp_pkg::REG_MAX_SPEED:  cfg_in.max_speed = csr_pwdata[tsmp_pkg::MaxW-1:0];
            tsmp_pkg::REG_ACCEL_RATE: cfg_in.accel_rate = csr_pwdata[tsmp_pkg::RateW-1:0];
            tsmp_pkg::REG_DECEL_RATE: cfg_in.decel_rate = csr_pwdata[tsmp_pkg::RateW-1:0];
            tsmp_pkg::REG_REACH_TOL:  cfg_in.reach_tolerance = csr_pwdata[tsmp_pkg::TolW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed       <= tsmp_pkg::MAX_SPEED_RST;
         cfg_ff.accel_rate      <= tsmp_pkg::ACCEL_RST;
         cfg_ff.decel_rate      <= tsmp_pkg::DECEL_RST;
         cfg_ff.reach_tolerance <= tsmp_pkg::TOL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data, zero extended.
   always_comb begin
      unique case (index)
         tsmp_pkg::REG_MAX_SPEED:  csr_prdata = 32'(cfg_ff.max_speed);
         tsmp_pkg::REG_ACCEL_RATE: csr_prdata = 32'(cfg_ff.accel_rate);
         tsmp_pkg::REG_DECEL_RATE: csr_prdata = 32'(cfg_ff.decel_rate);
         tsmp_pkg::REG_REACH_TOL:  csr_prdata = 32'(cfg_ff.reach_tolerance);
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

### src/tsmp_mul.sv
`timescale 1ns / 1ps

module tsmp_mul (
   input  logic                                 clock,
   input  logic signed [tsmp_pkg::MulAW-1:0]    mul_a,
   input  logic signed [tsmp_pkg::MulBW-1:0]    mul_b,
   output logic signed [tsmp_pkg::ProdW-1:0]    product
);

   logic signed [tsmp_pkg::ProdW-1:0] product_ff;
   logic signed [tsmp_pkg::ProdW-1:0] product_in;

   // Full signed product, registered before use.
   assign product_in = mul_a * mul_b;
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### src/target_seeking_motion_profile.sv
`timescale 1ns / 1ps

// Target-seeking motion profile with acceleration limit.
// Request channel (req_): one transfer per tick carries a target position
// (Q2.14) and a time step (Q0.16 s). Response channel (rsp_): one transfer
// per tick returns the new position, the new speed and a flag telling whether
// the target was within the reach tolerance at the start of the tick.
// After the request transfer a tick works in steps: one product of
// rate and time step, one speed update, one product of speed and time step,
// and the position update. Both products go through a single shared
// multiplier, so the steps run one after another. The block takes no new
// request until the current tick commits; req_ready is high only while the
// sequencer is idle.
// The response sits in an output register; while the receiver stalls, the
// next tick may still be accepted and computed, but it holds in its last step
// until the output register is free.
// Reset clears position and speed to zero and loads the register defaults.
// The registers (max_speed, accel_rate, decel_rate, reach_tolerance at byte
// addresses 0, 4, 8, 12) should be written only while the block is idle.
module target_seeking_motion_profile (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tsmp_pkg::PosW-1:0]     req_target_position,
   input  logic [tsmp_pkg::StepW-1:0]           req_time_step,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tsmp_pkg::PosW-1:0]     rsp_position,
   output logic signed [tsmp_pkg::SpdW-1:0]     rsp_speed,
   output logic                                 rsp_target_reached,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [3:0]                           csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int OffW = tsmp_pkg::PosW + 1;
   localparam int SumW = tsmp_pkg::RateW + 2;
   localparam int DelW = tsmp_pkg::SpdW + 1;
   localparam int PsW  = tsmp_pkg::PosW + 6;

   tsmp_pkg::cfg_type       cfg;
   tsmp_pkg::seq_state_type state_ff, state_in;

   logic signed [tsmp_pkg::PosW-1:0]  pos_ff, pos_in;
   logic signed [tsmp_pkg::SpdW-1:0]  spd_ff, spd_in;
   logic signed [tsmp_pkg::PosW-1:0]  target_ff;
   logic [tsmp_pkg::StepW-1:0]        dt_ff;
   logic                              reached_ff, to_pos_ff, to_neg_ff, decel_ff;
   logic signed [tsmp_pkg::SpdW-1:0]  spd_new_ff, spd_new_in;
   logic                              rsp_valid_ff;
   logic signed [tsmp_pkg::PosW-1:0]  rsp_position_ff;
   logic signed [tsmp_pkg::SpdW-1:0]  rsp_speed_ff;
   logic                              rsp_reached_ff;

   logic                              load_req, eval_dir, load_spd, commit_go, sel_move;
   logic                              out_free;

   logic signed [tsmp_pkg::MulAW-1:0] mul_a;
   logic signed [tsmp_pkg::MulBW-1:0] mul_b;
   logic signed [tsmp_pkg::ProdW-1:0] product;

   logic signed [OffW-1:0]            offset, tol_ext;
   logic                              reached, to_pos, to_neg, decel;
   logic [tsmp_pkg::RateW-1:0]        rate_sel, dspd;
   logic signed [SumW-1:0]            spd_ext, dspd_ext, spd_sum, spd_lim;
   logic [tsmp_pkg::MaxW-1:0]         limit;
   logic signed [DelW-1:0]            pos_delta;
   logic signed [PsW-1:0]             pos_sum;
   logic                              pos_hi, pos_lo;

   function automatic logic signed [tsmp_pkg::MulAW-1:0] MulAWExt(
      input logic signed [tsmp_pkg::SpdW-1:0] v);
      MulAWExt = tsmp_pkg::MulAW'(v);
   endfunction

   tsmp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsmp_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Sequencer: next state and step strobes.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load_req  = 1'b0;
      eval_dir  = 1'b0;
      load_spd  = 1'b0;
      sel_move  = 1'b0;
      commit_go = 1'b0;
      unique case (state_ff)
         tsmp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               load_req = 1'b1;
               state_in = tsmp_pkg::ST_RATE;
            end
         end
         tsmp_pkg::ST_RATE: begin
            eval_dir = 1'b1;
            state_in = tsmp_pkg::ST_SPEED;
         end
         tsmp_pkg::ST_SPEED: begin
            load_spd = 1'b1;
            state_in = tsmp_pkg::ST_MOVE;
         end
         tsmp_pkg::ST_MOVE: begin
            sel_move = 1'b1;
            state_in = tsmp_pkg::ST_COMMIT;
         end
         tsmp_pkg::ST_COMMIT: begin
            // Keep the speed product in the multiplier while the tick waits.
            sel_move = 1'b1;
            if (out_free) begin
               commit_go = 1'b1;
               state_in  = tsmp_pkg::ST_IDLE;
            end
         end
         default: state_in = tsmp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsmp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Offset to the target, reach test and direction of the speed change.
   assign offset  = OffW'(target_ff) - OffW'(pos_ff);
   assign tol_ext = $signed({2'b00, cfg.reach_tolerance});
   assign reached = (offset > -tol_ext) && (offset < tol_ext);
   assign to_pos  = offset > 0;
   assign to_neg  = offset < 0;
   assign decel   = (to_pos && spd_ff < 0) || (to_neg && spd_ff > 0);
   assign rate_sel = decel ? cfg.decel_rate : cfg.accel_rate;

   // Multiplier operands: rate times step first, then speed times step.
   assign mul_a = sel_move ? MulAWExt(spd_new_ff) : $signed({1'b0, rate_sel});
   assign mul_b = $signed({1'b0, dt_ff});

   // Speed update: zero if reached, else one add or subtract, stop at zero when braking, then limit.
   assign dspd     = product[tsmp_pkg::RateW+15:16];
   assign spd_ext  = SumW'(spd_ff);
   assign dspd_ext = $signed({2'b00, dspd});
   assign limit    = (cfg.max_speed > tsmp_pkg::SPEED_CAP) ? tsmp_pkg::SPEED_CAP
                                                          : cfg.max_speed;

   always_comb begin
      if (reached_ff) begin
         spd_sum = '0;
      end else if (to_pos_ff) begin
         spd_sum = spd_ext + dspd_ext;
         if (decel_ff && spd_sum > 0) begin
            spd_sum = '0;
         end
      end else if (to_neg_ff) begin
         spd_sum = spd_ext - dspd_ext;
         if (decel_ff && spd_sum < 0) begin
            spd_sum = '0;
         end
      end else begin
         spd_sum = spd_ext;
      end
      spd_lim = spd_sum;
      if (spd_sum > $signed({12'd0, limit})) begin
         spd_lim = $signed({12'd0, limit});
      end else if (spd_sum < -$signed({12'd0, limit})) begin
         spd_lim = -$signed({12'd0, limit});
      end
      spd_new_in = spd_lim[tsmp_pkg::SpdW-1:0];
   end

   // Position update with clamping to the travel range.
   assign pos_delta = product[DelW+15:16];
   assign pos_sum   = PsW'(pos_ff) + PsW'(pos_delta);
   assign pos_hi    = pos_sum > PsW'(tsmp_pkg::POS_ONE);
   assign pos_lo    = pos_sum < -PsW'(tsmp_pkg::POS_ONE);

   always_comb begin
      pos_in = pos_sum[tsmp_pkg::PosW-1:0];
      spd_in = spd_new_ff;
      if (pos_hi) begin
         pos_in = tsmp_pkg::POS_ONE;
         spd_in = '0;
      end else if (pos_lo) begin
         pos_in = -tsmp_pkg::POS_ONE;
         spd_in = '0;
      end
   end

   // Working registers of one tick.
   always_ff @(posedge clock) begin
      if (load_req) begin
         target_ff <= req_target_position;
         dt_ff     <= req_time_step;
      end
      if (eval_dir) begin
         reached_ff <= reached;
         to_pos_ff  <= to_pos;
         to_neg_ff  <= to_neg;
         decel_ff   <= decel;
      end
      if (load_spd) begin
         spd_new_ff <= spd_new_in;
      end
   end

   // Kept state: position and speed.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         spd_ff <= '0;
      end else if (commit_go) begin
         pos_ff <= pos_in;
         spd_ff <= spd_in;
      end
   end

   // Output register of the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_go) begin
         rsp_position_ff <= pos_in;
         rsp_speed_ff    <= spd_in;
         rsp_reached_ff  <= reached_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_speed          = rsp_speed_ff;
   assign rsp_target_reached = rsp_reached_ff;

   // A new response appears only from the last step of a tick.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tsmp_pkg::ST_COMMIT))
      else $error("response raised outside the commit step");

   // A finished tick waits while the output register is still occupied.
   a_commit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsmp_pkg::ST_COMMIT && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == tsmp_pkg::ST_COMMIT && $stable(pos_ff)))
      else $error("tick committed over a pending response");

   // Kept position stays within the travel range.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= tsmp_pkg::POS_ONE) && (pos_ff >= -tsmp_pkg::POS_ONE))
      else $error("position left the travel range");

   // Kept speed never exceeds the hard limit.
   a_spd_range: assert property (@(posedge clock) disable iff (reset)
      (spd_ff <= $signed({1'b0, tsmp_pkg::SPEED_CAP}))
      && (spd_ff >= -$signed({1'b0, tsmp_pkg::SPEED_CAP})))
      else $error("speed beyond the hard limit");

   // Position and speed change only when a tick commits.
   a_state_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tsmp_pkg::ST_COMMIT) |=> ($stable(pos_ff) && $stable(spd_ff)))
      else $error("kept state changed outside a commit");

endmodule
